/* hw/rtl/usv_pkg.sv */
`timescale 1ns / 1ps
// Package for the UTF-8 stream validator: job type passed from front to back,
// status codes and the byte/code point classification functions. No dependencies.
package usv_pkg;

   localparam logic [1:0] STATUS_VALID      = 2'd0;
   localparam logic [1:0] STATUS_ILLEGAL    = 2'd1;
   localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;

   // One finished character or one error, as queued for the back end.
   // bytes[last_idx] is the final beat; lower entries go out first.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic [20:0]     cp;
      logic [1:0]      status;
   } usv_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } usv_fifo_status_type;

   // Sequence length from the lead byte; 0 marks an illegal lead.
   function automatic logic [2:0] seq_length(input logic [7:0] b);
      logic [2:0] n;
      n = 3'd0;
      if (b inside {[8'h00:8'h7F]}) n = 3'd1;
      else if (b inside {[8'hC2:8'hDF]}) n = 3'd2;
      else if (b inside {[8'hE0:8'hEF]}) n = 3'd3;
      else if (b inside {[8'hF0:8'hF4]}) n = 3'd4;
      return n;
   endfunction

   // Second-byte range check; the narrowed ranges exclude overlongs and surrogates.
   function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = 8'h80;
      hi = 8'hBF;
      if (lead == 8'hE0) lo = 8'hA0;
      else if (lead == 8'hED) hi = 8'h9F;
      else if (lead == 8'hF0) lo = 8'h90;
      else if (lead == 8'hF4) hi = 8'h8F;
      return (b >= lo) && (b <= hi);
   endfunction

   // Noncharacters and values beyond 10FFFD.
   function automatic logic cp_rejected(input logic [20:0] cp);
      return (cp[15:0] == 16'hFFFE) || (cp[15:0] == 16'hFFFF) ||
             ((cp >= 21'h00FDD0) && (cp <= 21'h00FDEF)) || (cp > 21'h10FFFD);
   endfunction

endpackage

/* hw/rtl/usv_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input bytes, tracks the partial character and pushes one
// job per finished character or error. Uses usv_pkg.
module usv_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   input  logic                req_end_of_input,
   input  usv_pkg::usv_fifo_status_type fifo_status,
   output logic                push,
   output usv_pkg::usv_job_type push_job
);
   import usv_pkg::*;

   logic [2:0]       len_ff, len_in;
   logic [1:0]       seen_ff, seen_in;
   logic [2:0][7:0]  held_ff, held_in;
   logic [20:0]      acc_ff, acc_in;
   logic             bad_ff, bad_in;
   logic             halted_ff, halted_in;

   logic             accept;
   logic [2:0]       n_lead;
   logic [20:0]      acc_next;
   logic             bad_next;
   logic [1:0]       len_m1;
   logic [7:0]       b;
   logic             eoi;

   assign req_stall = fifo_status.full;
   assign accept    = req_valid && !req_stall;
   assign b         = req_in_byte;
   assign eoi       = req_end_of_input;
   assign n_lead    = seq_length(b);
   assign acc_next  = {acc_ff[14:0], b[5:0]};
   assign bad_next  = bad_ff | ((seen_ff == 2'd1) ? !second_ok(held_ff[0], b)
                                                  : ((b < 8'h80) || (b > 8'hBF)));
   assign len_m1    = 2'(len_ff - 3'd1);

   always_comb begin
      len_in    = len_ff;
      seen_in   = seen_ff;
      held_in   = held_ff;
      acc_in    = acc_ff;
      bad_in    = bad_ff;
      halted_in = halted_ff;
      push      = 1'b0;
      push_job  = '0;
      if (accept) begin
         if (halted_ff) begin
            if (eoi) halted_in = 1'b0;
         end else if (len_ff == 3'd0) begin
            if (n_lead == 3'd0) begin
               push            = 1'b1;
               push_job.status = STATUS_ILLEGAL;
               halted_in       = !eoi;
            end else if (n_lead == 3'd1) begin
               push              = 1'b1;
               push_job.bytes[0] = b;
               push_job.cp       = {13'd0, b};
               push_job.status   = STATUS_VALID;
            end else if (eoi) begin
               // lone lead byte at end of buffer
               push            = 1'b1;
               push_job.status = STATUS_INCOMPLETE;
            end else begin
               len_in     = n_lead;
               seen_in    = 2'd1;
               held_in[0] = b;
               bad_in     = 1'b0;
               case (n_lead)
                  3'd2:    acc_in = {16'd0, b[4:0]};
                  3'd3:    acc_in = {17'd0, b[3:0]};
                  default: acc_in = {18'd0, b[2:0]};
               endcase
            end
         end else if ({1'b0, seen_ff} + 3'd1 < len_ff) begin
            if (eoi) begin
               push            = 1'b1;
               push_job.status = STATUS_INCOMPLETE;
               len_in          = 3'd0;
               bad_in          = 1'b0;
            end else begin
               held_in[seen_ff] = b;
               seen_in          = seen_ff + 2'd1;
               acc_in           = acc_next;
               bad_in           = bad_next;
            end
         end else begin
            push   = 1'b1;
            len_in = 3'd0;
            bad_in = 1'b0;
            if (bad_next || cp_rejected(acc_next)) begin
               push_job.status = STATUS_ILLEGAL;
               halted_in       = !eoi;
            end else begin
               push_job.bytes         = {8'h00, held_ff[2], held_ff[1], held_ff[0]};
               push_job.bytes[len_m1] = b;
               push_job.last_idx      = len_m1;
               push_job.cp            = acc_next;
               push_job.status        = STATUS_VALID;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= 3'd0;
         seen_ff   <= 2'd0;
         acc_ff    <= 21'd0;
         bad_ff    <= 1'b0;
         halted_ff <= 1'b0;
      end else begin
         len_ff    <= len_in;
         seen_ff   <= seen_in;
         acc_ff    <= acc_in;
         bad_ff    <= bad_in;
         halted_ff <= halted_in;
      end
      held_ff <= held_in;
   end

`ifndef SYNTHESIS
   a_halt_idle: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> (len_ff == 3'd0))
      else $error("front halted with a partial character");
   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      (len_ff != 3'd0) |-> (({1'b0, seen_ff} < len_ff) && (seen_ff != 2'd0)))
      else $error("front byte count out of range");
`endif

endmodule

/* hw/rtl/usv_fifo.sv */
`timescale 1ns / 1ps
// Job queue between front and back ends; register array with one read port.
// Uses usv_pkg.
module usv_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  usv_pkg::usv_job_type push_job,
   input  logic                 pop,
   output usv_pkg::usv_job_type pop_job,
   output usv_pkg::usv_fifo_status_type status
);
   import usv_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   usv_job_type        mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_job      = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_job;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("job queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("job queue underflow");
`endif

endmodule

/* hw/rtl/usv_back.sv */
`timescale 1ns / 1ps
// Back end: takes jobs from the queue and plays each out as one to four
// result beats. Uses usv_pkg.
module usv_back (
   input  logic                 clock,
   input  logic                 reset,
   input  usv_pkg::usv_fifo_status_type fifo_status,
   input  usv_pkg::usv_job_type pop_job,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic [20:0]          rsp_code_point,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last
);
   import usv_pkg::*;

   usv_job_type job_ff, job_in;
   logic [1:0]  idx_ff, idx_in;
   logic        active_ff, active_in;
   logic        advance;
   logic        done;

   assign rsp_valid      = active_ff;
   assign rsp_out_byte   = job_ff.bytes[idx_ff];
   assign rsp_code_point = job_ff.cp;
   assign rsp_status     = job_ff.status;
   assign rsp_last       = (idx_ff == job_ff.last_idx);

   assign advance = active_ff && !rsp_stall;
   assign done    = !active_ff || (advance && rsp_last);
   assign pop     = done && !fifo_status.empty;

   always_comb begin
      job_in    = job_ff;
      idx_in    = idx_ff;
      active_in = active_ff;
      if (done) begin
         active_in = !fifo_status.empty;
         idx_in    = 2'd0;
         if (pop) job_in = pop_job;
      end else if (advance) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= 2'd0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
      job_ff <= job_in;
   end

`ifndef SYNTHESIS
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff <= job_ff.last_idx))
      else $error("beat index past end of job");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (active_ff && rsp_stall) |=> (active_ff && $stable(idx_ff)))
      else $error("beat advanced while stalled");
`endif

endmodule

/* hw/rtl/utf8_stream_validator_top.sv */
`timescale 1ns / 1ps
// Top level of the UTF-8 stream validator: front end, job queue and back end.
// Uses usv_pkg, usv_front, usv_fifo and usv_back.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_in_byte, req_end_of_input
//   rsp      out  rsp_valid/rsp_stall  rsp_out_byte, rsp_code_point, rsp_status, rsp_last
//
// One input beat per clock is taken whenever the job queue has room; the
// back end sends one result beat per clock while rsp_stall is low. After the
// input beat that finishes a job is taken, the job is written into the queue,
// then loaded into the back-end job register, where it raises rsp_valid.
// Reset is synchronous and clears the character state, queue and back end.
// A stall on rsp fills the queue (JOB_DEPTH jobs), then raises req_stall.
module utf8_stream_validator_top #(
   parameter int JOB_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [20:0] rsp_code_point,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);
   import usv_pkg::*;

   // front -> queue
   logic                push;
   usv_job_type         push_job;
   // queue -> back
   logic                pop;
   usv_job_type         pop_job;
   usv_fifo_status_type fifo_status;

   // Front end: decodes and checks characters, one job per completion/error.
   usv_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .fifo_status      (fifo_status),
      .push             (push),
      .push_job         (push_job)
   );

   // Queue decouples the input side from output backpressure.
   usv_fifo #(
      .DEPTH (JOB_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (fifo_status)
   );

   // Back end: expands each job into its result beats.
   usv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .fifo_status    (fifo_status),
      .pop_job        (pop_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_code_point (rsp_code_point),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

`ifndef SYNTHESIS
   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      push |-> (req_valid && !req_stall))
      else $error("job pushed without an accepted input beat");
`endif

endmodule
